// ===== rtl/pcm_format_convert_channel_pad_defines.svh =====
// ============================================================================
// PCM format convert assertion macros
// Concurrent assertion wrappers shared by the RTL; empty for synthesis.
// ============================================================================
`ifndef PCM_FORMAT_CONVERT_CHANNEL_PAD_DEFINES_SVH
`define PCM_FORMAT_CONVERT_CHANNEL_PAD_DEFINES_SVH

`ifndef SYNTHESIS
// check a property on every clock edge outside reset
`define PCMFC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pcmfc assertion failed");
// check a property on every clock edge, reset included
`define PCMFC_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("pcmfc assertion failed");
`else
`define PCMFC_ASSERT(label, prop)
`define PCMFC_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== rtl/pcmfc_pkg.sv =====
// ============================================================================
// PCM format convert package
// Widths, register indexes, sample formats and conversion functions.
// ============================================================================
package pcmfc_pkg;

    localparam int DEFAULT_MAX_CHANNELS = 32;
    localparam int CFG_INDEX_W          = 2;
    localparam int CFG_DATA_W           = 6;
    localparam int FMT_W                = 2;
    localparam int COUNT_W              = 6;
    localparam int CHAN_W               = 5;
    localparam int SAMPLE_W             = 32;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SOURCE_FORMAT   = 2'd0,
        CFG_TARGET_FORMAT   = 2'd1,
        CFG_SOURCE_CHANNELS = 2'd2,
        CFG_OUTPUT_CHANNELS = 2'd3
    } cfg_index_t;

    // sample encodings
    typedef enum logic [FMT_W-1:0] {
        FMT_S16 = 2'd0,
        FMT_S24 = 2'd1,
        FMT_S32 = 2'd2
    } fmt_t;

    // widen raw bytes to a left-justified 32-bit sample
    function automatic logic [SAMPLE_W-1:0] widen(logic [SAMPLE_W-1:0] raw,
                                                   logic [FMT_W-1:0] fmt);
        logic [SAMPLE_W-1:0] v;
        v = '0;
        unique case (fmt)
            FMT_S16: v = {raw[15:0], 16'h0000};
            FMT_S24: v = {raw[23:0], 8'h00};
            FMT_S32: v = raw;
            default: v = '0;
        endcase
        return v;
    endfunction

    // keep the upper bits for the target width, upper bytes zero
    function automatic logic [SAMPLE_W-1:0] narrow(logic [SAMPLE_W-1:0] v,
                                                    logic [FMT_W-1:0] fmt);
        logic [SAMPLE_W-1:0] r;
        r = '0;
        unique case (fmt)
            FMT_S16: r = {16'h0000, v[31:16]};
            FMT_S24: r = {8'h00, v[31:8]};
            FMT_S32: r = v;
            default: r = '0;
        endcase
        return r;
    endfunction

    // saturate a channel count to 1..lim
    function automatic logic [COUNT_W-1:0] clamp_count(logic [COUNT_W-1:0] n,
                                                        logic [COUNT_W-1:0] lim);
        logic [COUNT_W-1:0] r;
        r = n;
        if (n == '0)
        begin
            r = COUNT_W'(1);
        end
        else if (n > lim)
        begin
            r = lim;
        end
        return r;
    endfunction

endpackage

// ===== rtl/pcm_format_convert_channel_pad.sv =====
// ============================================================================
// PCM format convert with channel padding
// Converts interleaved PCM samples between 16/24/32-bit signed formats and
// pads each frame with zero samples up to the output channel count.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready/in_bytes) takes one source sample per
//   beat, interleaved by channel. Output channel (out_valid/out_ready) gives
//   one converted sample per beat with its channel index and a frame_end
//   flag on the last sample of each output frame.
//   Configuration is written through cfg_write/cfg_index/cfg_data while the
//   block is idle; writes do not restart the frame position.
//   A sample accepted into the input register moves on to the result
//   register once that is free and no padding is under way.
//   Throughput: one beat per cycle in both directions while the receiver
//   is ready and no padding is under way. The last source sample of a
//   frame produces 1 + (output count - source count) output beats when
//   the output count is larger, one per cycle from the padding counter
//   while the receiver is ready; the input stage holds the next sample.
//   A stalled receiver holds the result register; the input register still
//   takes one more beat before in_ready drops.
//   Reset: clears the frame position, empties both registers and loads the
//   register defaults (16-bit in, 16-bit out, two channels each).
// ============================================================================
`include "pcm_format_convert_channel_pad_defines.svh"

module pcm_format_convert_channel_pad #(
    parameter int MAX_CHANNELS = pcmfc_pkg::DEFAULT_MAX_CHANNELS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_write,
    input  logic [pcmfc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pcmfc_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input samples
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [pcmfc_pkg::SAMPLE_W-1:0]      in_bytes,
    // output samples
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [pcmfc_pkg::SAMPLE_W-1:0]      out_bytes,
    output logic [pcmfc_pkg::CHAN_W-1:0]        out_channel,
    output logic                                frame_end
);
    import pcmfc_pkg::*;

    localparam int CH_LIMIT = (MAX_CHANNELS < 32) ? MAX_CHANNELS : 32;
    localparam logic [COUNT_W-1:0] CH_LIMIT_L = COUNT_W'(CH_LIMIT);

    // configuration registers
    logic [FMT_W-1:0]   src_fmt_reg;
    logic [FMT_W-1:0]   tgt_fmt_reg;
    logic [COUNT_W-1:0] src_ch_reg;
    logic [COUNT_W-1:0] out_ch_reg;

    // input stage
    logic                in_full_reg;
    logic [SAMPLE_W-1:0] in_bytes_reg;

    // frame and padding state
    logic [CHAN_W-1:0] pos_reg;
    logic [CHAN_W-1:0] pos_next;
    logic              pad_active_reg;
    logic              pad_active_next;
    logic [CHAN_W-1:0] pad_ch_reg;
    logic [CHAN_W-1:0] pad_ch_next;

    // result register
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [SAMPLE_W-1:0] out_bytes_reg;
    logic [SAMPLE_W-1:0] out_bytes_next;
    logic [CHAN_W-1:0]   out_channel_reg;
    logic [CHAN_W-1:0]   out_channel_next;
    logic                frame_end_reg;
    logic                frame_end_next;

    logic                out_free;
    logic                advance;
    logic [COUNT_W-1:0]  sc;
    logic [COUNT_W-1:0]  oc;
    logic [SAMPLE_W-1:0] sample;
    logic                not_last;
    logic [CHAN_W-1:0]   last_ch;
    logic                pad_last;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_fmt_reg <= FMT_S16;
            tgt_fmt_reg <= FMT_S16;
            src_ch_reg  <= COUNT_W'(2);
            out_ch_reg  <= COUNT_W'(2);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SOURCE_FORMAT:   src_fmt_reg <= cfg_data[FMT_W-1:0];
                CFG_TARGET_FORMAT:   tgt_fmt_reg <= cfg_data[FMT_W-1:0];
                CFG_SOURCE_CHANNELS: src_ch_reg  <= cfg_data;
                CFG_OUTPUT_CHANNELS: out_ch_reg  <= cfg_data;
                default:             ;
            endcase
        end
    end

    // handshake: input register drains into the result register
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_full_reg && !pad_active_reg && out_free;
    assign in_ready = !in_full_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_full_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_bytes_reg <= in_bytes;
        end
    end

    // sample conversion and frame position
    assign sc       = clamp_count(src_ch_reg, CH_LIMIT_L);
    assign oc       = clamp_count(out_ch_reg, CH_LIMIT_L);
    assign sample   = narrow(widen(in_bytes_reg, src_fmt_reg), tgt_fmt_reg);
    assign not_last = ({1'b0, pos_reg} + COUNT_W'(1)) < sc;
    assign last_ch  = CHAN_W'(sc - COUNT_W'(1));
    assign pad_last = ({1'b0, pad_ch_reg} + COUNT_W'(1)) == oc;

    // next state: padding has priority over the waiting input beat
    always_comb
    begin
        pos_next         = pos_reg;
        pad_active_next  = pad_active_reg;
        pad_ch_next      = pad_ch_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_bytes_next   = out_bytes_reg;
        out_channel_next = out_channel_reg;
        frame_end_next   = frame_end_reg;
        if (out_free)
        begin
            priority if (pad_active_reg)
            begin
                out_valid_next   = 1'b1;
                out_bytes_next   = '0;
                out_channel_next = pad_ch_reg;
                frame_end_next   = pad_last;
                if (pad_last)
                begin
                    pad_active_next = 1'b0;
                end
                else
                begin
                    pad_ch_next = pad_ch_reg + CHAN_W'(1);
                end
            end
            else if (in_full_reg)
            begin
                out_valid_next = 1'b1;
                out_bytes_next = sample;
                if (not_last)
                begin
                    out_channel_next = pos_reg;
                    frame_end_next   = 1'b0;
                    pos_next         = pos_reg + CHAN_W'(1);
                end
                else
                begin
                    // last source channel; also covers a shrunk channel count
                    out_channel_next = last_ch;
                    frame_end_next   = (oc <= sc);
                    pos_next         = '0;
                    if (oc > sc)
                    begin
                        pad_active_next = 1'b1;
                        pad_ch_next     = sc[CHAN_W-1:0];
                    end
                end
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            pad_active_reg <= 1'b0;
            pad_ch_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            pad_active_reg <= pad_active_next;
            pad_ch_reg     <= pad_ch_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_bytes_reg   <= out_bytes_next;
        out_channel_reg <= out_channel_next;
        frame_end_reg   <= frame_end_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_bytes   = out_bytes_reg;
    assign out_channel = out_channel_reg;
    assign frame_end   = frame_end_reg;

    // checks
    `PCMFC_ASSERT(a_pad_has_result, pad_active_reg |-> out_valid_reg)
    `PCMFC_ASSERT(a_pad_blocks_input, (pad_active_reg && in_full_reg) |-> !in_ready)
    `PCMFC_ASSERT(a_pad_after_ch, pad_active_reg |-> (pad_ch_reg == out_channel_reg + CHAN_W'(1)))
    `PCMFC_ASSERT(a_pad_not_after_end, pad_active_reg |-> !frame_end_reg)
    `PCMFC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!out_valid_reg || rst_n))

endmodule

// ===== tb/testbench.sv =====
// ============================================================================
// PCM format convert channel pad testbench
// Streams interleaved samples through the converter under several register
// setups, predicts every output beat (converted sample, zero padding,
// channel index, frame_end) and checks them in order. Both handshakes stall
// at random, with one calm stretch where neither side idles.
// ============================================================================
module testbench;
    import pcmfc_pkg::*;

    // reserved encoding: reads as zero on input, gives zero on output
    localparam logic [FMT_W-1:0] FMT_NONE = 2'd3;
    localparam int IDLE_PCT    = 36;
    localparam int RANDOM_ITEMS = 80;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 8;

    // one expected output beat
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [CHAN_W-1:0]   chan;
        logic                closes;
    } pcm_beat_t;

    // predicts the beats of each accepted sample and checks arriving beats
    class pcm_frame_scoreboard;
        logic [FMT_W-1:0]   src_fmt;
        logic [FMT_W-1:0]   dst_fmt;
        logic [COUNT_W-1:0] src_count;
        logic [COUNT_W-1:0] out_count;
        logic [CHAN_W-1:0]  frame_pos;
        pcm_beat_t          frame_beats_due[$];
        int                 mismatches;
        int                 beats_checked;
        int                 samples_seen;

        function new();
            src_fmt       = FMT_S16;
            dst_fmt       = FMT_S16;
            src_count     = 6'd2;
            out_count     = 6'd2;
            frame_pos     = '0;
            mismatches    = 0;
            beats_checked = 0;
            samples_seen  = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [COUNT_W-1:0] val);
            case (idx)
                CFG_SOURCE_FORMAT:   src_fmt = val[FMT_W-1:0];
                CFG_TARGET_FORMAT:   dst_fmt = val[FMT_W-1:0];
                CFG_SOURCE_CHANNELS: src_count = val;
                CFG_OUTPUT_CHANNELS: out_count = val;
                default: ;
            endcase
        endfunction

        // channel counts saturate to 1..32
        function int clamp_channels(logic [COUNT_W-1:0] n);
            if (n == 0)
                return 1;
            if (n > DEFAULT_MAX_CHANNELS)
                return DEFAULT_MAX_CHANNELS;
            return int'(n);
        endfunction

        function void predict_frame_beats(logic [SAMPLE_W-1:0] raw);
            logic [SAMPLE_W-1:0] wide;
            logic [SAMPLE_W-1:0] conv;
            int                  sc;
            int                  oc;
            pcm_beat_t           b;
            sc = clamp_channels(src_count);
            oc = clamp_channels(out_count);
            samples_seen++;
            // left-justify; for 24-bit the sign bits fall off the top anyway
            case (src_fmt)
                FMT_S16: wide = raw << 16;
                FMT_S24: wide = raw << 8;
                FMT_S32: wide = raw;
                default: wide = '0;
            endcase
            // truncate to the target width, upper bytes zero
            case (dst_fmt)
                FMT_S16: conv = wide >> 16;
                FMT_S24: conv = wide >> 8;
                FMT_S32: conv = wide;
                default: conv = '0;
            endcase
            // mid-frame sample
            if (int'(frame_pos) + 1 < sc)
            begin
                b.sample = conv;
                b.chan   = frame_pos;
                b.closes = 1'b0;
                frame_beats_due.push_back(b);
                frame_pos = frame_pos + 1'b1;
                return;
            end
            // last source channel, also taken when the count shrank mid-frame
            b.sample = conv;
            b.chan   = CHAN_W'(sc - 1);
            b.closes = (oc <= sc);
            frame_beats_due.push_back(b);
            for (int ch = sc; ch < oc; ch++)
            begin
                b.sample = '0;
                b.chan   = CHAN_W'(ch);
                b.closes = (ch + 1 == oc);
                frame_beats_due.push_back(b);
            end
            frame_pos = '0;
        endfunction

        function void check_beat(logic [SAMPLE_W-1:0] smp, logic [CHAN_W-1:0] ch,
                                 logic fe);
            pcm_beat_t want;
            beats_checked++;
            if (frame_beats_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("beat %0d unexpected: bytes %h ch %0d end %b",
                             beats_checked, smp, ch, fe);
                return;
            end
            want = frame_beats_due.pop_front();
            if (smp !== want.sample || ch !== want.chan || fe !== want.closes)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("beat %0d: expected bytes %h ch %0d end %b, got %h ch %0d end %b",
                             beats_checked, want.sample, want.chan, want.closes,
                             smp, ch, fe);
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [SAMPLE_W-1:0]    in_bytes;
    logic                   out_valid;
    logic                   out_ready;
    logic [SAMPLE_W-1:0]    out_bytes;
    logic [CHAN_W-1:0]      out_channel;
    logic                   frame_end;

    bit                     calm;
    int                     quiet_cycles;
    int                     setups;
    pcm_frame_scoreboard    sb = new();

    pcm_format_convert_channel_pad i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_bytes    (in_bytes),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_bytes   (out_bytes),
        .out_channel (out_channel),
        .frame_end   (frame_end)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: random back-pressure except in the calm stretch
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // monitor: register writes, accepted samples and beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write)
                sb.write_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                sb.predict_frame_beats(in_bytes);
            if (out_valid && out_ready)
                sb.check_beat(out_bytes, out_channel, frame_end);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // watchdog on a stuck handshake
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("pcm_format_convert_channel_pad regression: fail");
        $finish;
    end

    // one source sample beat; valid stays up after acceptance
    task automatic send_sample(logic [SAMPLE_W-1:0] raw);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_bytes <= raw;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // stop sending and let every predicted beat come out
    task automatic drain_stream();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.frame_beats_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic setup(logic [FMT_W-1:0] sf, logic [FMT_W-1:0] tf,
                         logic [CFG_DATA_W-1:0] sc, logic [CFG_DATA_W-1:0] oc);
        write_reg(CFG_SOURCE_FORMAT, CFG_DATA_W'(sf));
        write_reg(CFG_TARGET_FORMAT, CFG_DATA_W'(tf));
        write_reg(CFG_SOURCE_CHANNELS, sc);
        write_reg(CFG_OUTPUT_CHANNELS, oc);
        setups++;
    endtask

    // stimulus
    initial
    begin
        int                    sent;
        int                    phase;
        int                    plen;
        logic [FMT_W-1:0]      sf;
        logic [FMT_W-1:0]      tf;
        logic [CFG_DATA_W-1:0] sc;
        logic [CFG_DATA_W-1:0] oc;
        logic [SAMPLE_W-1:0]   raw;
        int                    leftover;

        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_SOURCE_FORMAT;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_bytes  = '0;
        calm      = 1'b0;
        setups    = 1;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset defaults: 16-bit to 16-bit, two channels; upper bytes ignored
        send_sample(32'h0000_0000);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h1234_8000);
        send_sample(32'hABCD_7FFF);
        drain_stream();

        // 24-bit sign boundary into 32-bit, padded frame
        setup(FMT_S24, FMT_S32, 6'd3, 6'd5);
        send_sample(32'h0080_0000);
        send_sample(32'hFF7F_FFFF);
        send_sample(32'h5A12_3456);
        drain_stream();

        // one source channel padded to the widest frame
        setup(FMT_S32, FMT_S16, 6'd1, 6'd32);
        send_sample(32'h8000_0001);
        send_sample(32'h7FFF_FFFF);
        drain_stream();

        // fewer output than source channels: no padding
        setup(FMT_S16, FMT_S24, 6'd4, 6'd2);
        send_sample(32'h0000_8000);
        send_sample(32'hFFFF_7FFF);
        send_sample(32'h0000_FFFF);
        send_sample(32'hC3C3_0001);
        drain_stream();

        // stop mid-frame, then shrink the source count below the position
        setup(FMT_S32, FMT_S32, 6'd8, 6'd8);
        for (int i = 0; i < 5; i++)
            send_sample($urandom);
        drain_stream();
        setup(FMT_S32, FMT_S32, 6'd3, 6'd6);
        send_sample(32'h0123_4567);
        send_sample(32'h89AB_CDEF);
        drain_stream();

        // reserved encodings on either side
        setup(FMT_NONE, FMT_S32, 6'd1, 6'd1);
        send_sample(32'hDEAD_BEEF);
        drain_stream();
        setup(FMT_S32, FMT_NONE, 6'd1, 6'd1);
        send_sample(32'hFFFF_FFFF);
        drain_stream();

        // out-of-range counts: zero acts as one, above 32 saturates
        setup(FMT_S24, FMT_S16, 6'd0, 6'd63);
        send_sample(32'h00FF_FFFF);
        drain_stream();
        setup(FMT_S16, FMT_S32, 6'd63, 6'd0);
        send_sample(32'h0000_8001);
        drain_stream();

        // random phases, each with a fresh setup; phase 2 never idles
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            sf = ($urandom_range(0, 9) == 0) ? FMT_NONE : FMT_W'($urandom_range(0, 2));
            tf = ($urandom_range(0, 9) == 0) ? FMT_NONE : FMT_W'($urandom_range(0, 2));
            case ($urandom_range(0, 7))
                0:       sc = CFG_DATA_W'($urandom_range(0, 63));
                1:       sc = 6'd1;
                default: sc = CFG_DATA_W'($urandom_range(1, 6));
            endcase
            case ($urandom_range(0, 7))
                0:       oc = CFG_DATA_W'($urandom_range(0, 63));
                1:       oc = CFG_DATA_W'($urandom_range(1, 32));
                default: oc = CFG_DATA_W'((sc > 28 ? 28 : sc) + $urandom_range(0, 4));
            endcase
            setup(sf, tf, sc, oc);
            calm = (phase == 2);
            plen = $urandom_range(8, 20);
            for (int i = 0; i < plen; i++)
            begin
                case ($urandom_range(0, 9))
                    0:       raw = 32'h0000_0000;
                    1:       raw = 32'hFFFF_FFFF;
                    2:       raw = 32'h8000_0000;
                    3:       raw = 32'h7FFF_FFFF;
                    4:       raw = {8'($urandom_range(0, 255)), 1'b1, 23'($urandom)};
                    5:       raw = {16'($urandom), 1'b1, 15'($urandom)};
                    default: raw = $urandom;
                endcase
                send_sample(raw);
            end
            sent = sent + plen;
            drain_stream();
            calm  = 1'b0;
            phase++;
        end

        // tail: anything arriving now is unexpected
        repeat (TAIL_CYCLES) @(posedge clk);
        leftover = sb.frame_beats_due.size();
        if (leftover != 0)
            $display("%0d expected beats never arrived", leftover);

        $display("covered %0d samples over %0d register setups, %0d beats checked",
                 sb.samples_seen, setups, sb.beats_checked);
        $display("%0d beat mismatches", sb.mismatches);
        if (sb.mismatches == 0 && leftover == 0)
            $display("pcm_format_convert_channel_pad regression: pass");
        else
            $display("pcm_format_convert_channel_pad regression: fail");
        $finish;
    end

endmodule
